// ===== hdl/ultrasonic_echo_range_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter - assertion macros
// Shared concurrent assertion shorthands, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGE_FILTER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGE_FILTER_DEFINES_SVH

// Same-cycle implication.
`define UERF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UERF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/uerf_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter - package
// Shared types, codes and constants for the front end, back end and top.
// ----------------------------------------------------------------------------
package uerf_pkg;

  localparam int TICK_W = 16;
  localparam int DIST_W = 9;
  localparam int STAT_W = 2;

  // floor(t * 17 / 1000) == (t * RECIP_MUL) >> RECIP_SHIFT for every 16-bit t
  localparam int                RECIP_SHIFT = 26;
  localparam logic [20:0]       RECIP_MUL   = 21'd1140851;
  localparam int                PROD_W      = TICK_W + 21;
  localparam int                CM_W        = PROD_W - RECIP_SHIFT;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [STAT_W-1:0] ST_STORED   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_START = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;
  localparam logic [STAT_W-1:0] ST_REJECTED = 2'd3;

  localparam logic [1:0] REG_WAIT_LIMIT   = 2'd0;
  localparam logic [1:0] REG_HIGH_LIMIT   = 2'd1;
  localparam logic [1:0] REG_MAX_DISTANCE = 2'd2;

  localparam logic [TICK_W-1:0] WAIT_LIMIT_RST   = 16'd10000;
  localparam logic [TICK_W-1:0] HIGH_LIMIT_RST   = 16'd50000;
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 9'd400;

  typedef struct packed {
    logic kind;
    logic echo;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] filtered_cm;
    logic [DIST_W-1:0] raw_cm;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    JOB_FINISH   = 2'd0,
    JOB_NO_START = 2'd1,
    JOB_TOO_LONG = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [TICK_W-1:0] ticks;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_MUL   = 3'd1,
    BK_STORE = 3'd2,
    BK_SUM   = 3'd3,
    BK_DIV   = 3'd4,
    BK_PUSH  = 3'd5
  } back_state_t;

endpackage

// ===== hdl/uerf_fifo.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter - small queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module uerf_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] din,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] dout,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] data_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hdl/uerf_front.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter - front end
// Track the echo phase and tick count; emit one job per finished measurement.
// ----------------------------------------------------------------------------
module uerf_front import uerf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_item_t          item,
  input  logic [TICK_W-1:0] wait_limit,
  input  logic [TICK_W-1:0] high_limit,
  output logic              job_push,
  output job_t              job
);

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;

  // Next phase and tick count
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    if (accept) begin
      if (item.kind == KIND_START) begin
        phase_nxt = PH_WAIT;
        tick_nxt  = '0;
      end else begin
        unique case (phase_r)
          PH_WAIT: begin
            if (item.echo) begin
              phase_nxt = PH_HIGH;
              tick_nxt  = '0;
            end else if (tick_r >= wait_limit) begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
            end else begin
              tick_nxt = tick_r + 1'b1;
            end
          end
          PH_HIGH: begin
            if (!item.echo || (tick_r >= high_limit)) begin
              phase_nxt = PH_IDLE;
              tick_nxt  = '0;
            end else begin
              tick_nxt = tick_r + 1'b1;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  // Job emission
  always_comb begin
    job_push  = 1'b0;
    job.kind  = JOB_FINISH;
    job.ticks = tick_r;
    if (accept && (item.kind == KIND_TICK)) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (!item.echo && (tick_r >= wait_limit)) begin
            job_push = 1'b1;
            job.kind = JOB_NO_START;
          end
        end
        PH_HIGH: begin
          if (!item.echo) begin
            job_push = 1'b1;
            job.kind = JOB_FINISH;
          end else if (tick_r >= high_limit) begin
            job_push = 1'b1;
            job.kind = JOB_TOO_LONG;
          end
        end
        default: job_push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
    end
  end

endmodule

// ===== hdl/uerf_back.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter - back end
// Convert ticks to cm, update the sample ring and average it serially.
// ----------------------------------------------------------------------------
module uerf_back import uerf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_empty,
  input  job_t              job,
  output logic              job_pop,
  input  logic [DIST_W-1:0] max_distance,
  input  logic              out_full,
  output logic              out_push,
  output out_item_t         result
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = DIST_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  back_state_t       state_r, state_nxt;
  job_t              job_r;
  logic [PROD_W-1:0] prod_r;
  logic [DIST_W-1:0] ring_mem_r [WINDOW];
  logic [SLOT_W-1:0] slot_r;
  logic              ring_full_r;
  logic [DIST_W-1:0] raw_r;
  logic [STAT_W-1:0] status_r;
  logic [CNT_W-1:0]  idx_r;
  logic [DIST_W-1:0] rd_r;
  logic              rd_vld_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;

  logic [CM_W-1:0]   cm_full;
  logic [DIST_W-1:0] cm_clamp;
  logic              store_ok;
  logic              slot_last;
  logic [CNT_W-1:0]  cnt;
  logic              rd_go;
  logic              sum_done;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;
  logic [CNT_W-1:0]  rem_nxt;
  logic              div_done;

  assign cm_full   = prod_r[PROD_W-1:RECIP_SHIFT];
  assign cm_clamp  = (cm_full > CM_W'(max_distance)) ? max_distance : cm_full[DIST_W-1:0];
  assign store_ok  = (cm_clamp != '0) && (cm_clamp < max_distance);
  assign slot_last = (slot_r == SLOT_W'(WINDOW - 1));
  assign cnt       = ring_full_r ? CNT_W'(WINDOW) : CNT_W'(slot_r);
  assign rd_go     = (state_r == BK_SUM) && (idx_r != cnt);
  assign sum_done  = (idx_r == cnt) && !rd_vld_r;
  assign trial     = {rem_r, q_r[SUM_W-1]};
  assign diff      = trial - {1'b0, cnt};
  assign ge        = (trial >= {1'b0, cnt});
  assign rem_nxt   = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  assign div_done  = (step_r == STEP_W'(SUM_W));

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          state_nxt = (job.kind == JOB_FINISH) ? BK_MUL : BK_SUM;
        end
      end
      BK_MUL:   state_nxt = BK_STORE;
      BK_STORE: state_nxt = BK_SUM;
      BK_SUM:   if (sum_done) state_nxt = BK_DIV;
      BK_DIV:   if (div_done) state_nxt = BK_PUSH;
      BK_PUSH:  if (!out_full) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    job_pop            = (state_r == BK_IDLE) && !job_empty;
    out_push           = (state_r == BK_PUSH) && !out_full;
    result.filtered_cm = (cnt == '0) ? DIST_W'(1) : q_r[DIST_W-1:0];
    result.raw_cm      = raw_r;
    result.status      = status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      slot_r      <= '0;
      ring_full_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_go;
      if ((state_r == BK_STORE) && store_ok) begin
        slot_r <= slot_last ? '0 : slot_r + 1'b1;
        if (slot_last) begin
          ring_full_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r    <= job;
      idx_r    <= '0;
      sum_r    <= '0;
      raw_r    <= '0;
      status_r <= (job.kind == JOB_NO_START) ? ST_NO_START : ST_TOO_LONG;
    end
    if (state_r == BK_MUL) begin
      prod_r <= PROD_W'(job_r.ticks) * PROD_W'(RECIP_MUL);
    end
    if (state_r == BK_STORE) begin
      raw_r    <= cm_clamp;
      status_r <= store_ok ? ST_STORED : ST_REJECTED;
    end
    if (state_r == BK_SUM) begin
      if (rd_go) begin
        idx_r <= idx_r + 1'b1;
      end
      if (rd_vld_r) begin
        sum_r <= sum_r + SUM_W'(rd_r);
      end
      if (sum_done) begin
        q_r    <= sum_r;
        rem_r  <= '0;
        step_r <= '0;
      end
    end
    if ((state_r == BK_DIV) && !div_done) begin
      q_r    <= {q_r[SUM_W-2:0], ge};
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  // Sample ring: one write port, one registered read port
  always_ff @(posedge clk) begin
    if ((state_r == BK_STORE) && store_ok) begin
      ring_mem_r[slot_r] <= cm_clamp;
    end
    if (rd_go) begin
      rd_r <= ring_mem_r[idx_r[SLOT_W-1:0]];
    end
  end

endmodule

// ===== hdl/ultrasonic_echo_range_filter.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter - top level
// Echo pulse timing, distance conversion and moving-average filtering.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload / fields
//  --------  ---------------------  ------------------------------------------
//  input     push / full            in_data  : kind, echo
//  result    pop / empty            out_data : filtered_cm, raw_cm, status
//  config    psel penable pwrite    paddr[3:2] selects register, pwdata, prdata
//
//  The front end takes one request per cycle while full is low; full rises
//  only when the two-entry job queue toward the back end is full.
//  A measurement result passes through the back end's serial ring read and
//  the one-bit per cycle divider; timeouts skip the multiply and store steps.
//  Reset is synchronous on rst_n; the sample ring needs no clearing pass.
//  A stalled result side backs up through the two-entry result queue and the
//  job queue before full is raised.
//
`include "ultrasonic_echo_range_filter_defines.svh"

module ultrasonic_echo_range_filter import uerf_pkg::*; #(
  parameter int WINDOW = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  in_item_t    in_data,
  // result channel
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [TICK_W-1:0] wait_limit_r;
  logic [TICK_W-1:0] high_limit_r;
  logic [DIST_W-1:0] max_distance_r;
  logic              cfg_wr;

  logic              in_accept;
  logic              jq_push;
  job_t              jq_din;
  logic              jq_full;
  logic              jq_pop;
  job_t              jq_dout;
  logic              jq_empty;
  logic              oq_push;
  out_item_t         oq_din;
  logic              oq_full;

  // Configuration registers: write on the access phase, read back live.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_limit_r   <= WAIT_LIMIT_RST;
      high_limit_r   <= HIGH_LIMIT_RST;
      max_distance_r <= MAX_DISTANCE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WAIT_LIMIT:   wait_limit_r   <= pwdata[TICK_W-1:0];
        REG_HIGH_LIMIT:   high_limit_r   <= pwdata[TICK_W-1:0];
        REG_MAX_DISTANCE: max_distance_r <= pwdata[DIST_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WAIT_LIMIT:   prdata = 32'(wait_limit_r);
      REG_HIGH_LIMIT:   prdata = 32'(high_limit_r);
      REG_MAX_DISTANCE: prdata = 32'(max_distance_r);
      default:          prdata = '0;
    endcase
  end

  // Hold every request while the job queue cannot take a possible job.
  assign full      = jq_full;
  assign in_accept = push && !full;

  uerf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .item       (in_data),
    .wait_limit (wait_limit_r),
    .high_limit (high_limit_r),
    .job_push   (jq_push),
    .job        (jq_din)
  );

  // Decouple the per-tick front end from the multi-cycle back end.
  uerf_fifo #(
    .DATA_W ($bits(job_t)),
    .DEPTH  (2)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (jq_push),
    .din   (jq_din),
    .full  (jq_full),
    .pop   (jq_pop),
    .dout  (jq_dout),
    .empty (jq_empty)
  );

  uerf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_empty    (jq_empty),
    .job          (jq_dout),
    .job_pop      (jq_pop),
    .max_distance (max_distance_r),
    .out_full     (oq_full),
    .out_push     (oq_push),
    .result       (oq_din)
  );

  // Result queue: the back end advances while the consumer stalls.
  uerf_fifo #(
    .DATA_W ($bits(out_item_t)),
    .DEPTH  (2)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_din),
    .full  (oq_full),
    .pop   (pop),
    .dout  (out_data),
    .empty (empty)
  );

  // Back end never drives a result into a full queue.
  `UERF_ASSERT_NOW(a_out_no_overflow, oq_push, !oq_full, "result queue overflow")

  // A start request re-arms the front end and never emits a job.
  `UERF_ASSERT_NOW(a_start_no_job, in_accept && (in_data.kind == KIND_START), !jq_push,
                   "start request produced a job")

  // A stored reading is always a nonzero distance.
  `UERF_ASSERT_NOW(a_stored_nonzero, !empty && (out_data.status == ST_STORED),
                   out_data.raw_cm != '0, "stored reading with zero distance")

  // A result handed to the queue is visible on the next cycle.
  `UERF_ASSERT_NEXT(a_push_visible, oq_push && !oq_full, !empty,
                    "pushed result not visible")

endmodule

// ===== dv/ultrasonic_echo_range_filter_tb.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic echo range filter - testbench
// Drives start and tick requests through the push/full queue port and
// reprograms the three limit registers between phases. Every request is run
// through a cycle-free model of the echo timer and the five-entry averaging
// ring, and each popped reading is compared field by field with the oldest
// predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ultrasonic_echo_range_filter_tb;
  import uerf_pkg::*;

  localparam int RING_DEPTH   = 5;
  localparam int DRAIN_CYCLES = 40;      // settle time after the last reading arrives
  localparam int DRAIN_LIMIT  = 200000;  // give up on a missing reading after this
  localparam int HOLD_CYCLES  = 400;     // long result-side hold-off
  localparam int CM_NUM       = 17;      // cm = ticks * 17 / 1000
  localparam int CM_DEN       = 1000;

  // --------------------------------------------------------------------------
  // Echo timer and averaging ring model, plus the queue of predicted readings
  // --------------------------------------------------------------------------
  class echo_range_scoreboard;
    logic [TICK_W-1:0] wait_limit;
    logic [TICK_W-1:0] high_limit;
    logic [DIST_W-1:0] max_distance;

    phase_t            phase;
    logic [TICK_W-1:0] tick_count;
    logic [DIST_W-1:0] ring_cm [RING_DEPTH];
    int unsigned       write_slot;
    bit                ring_full;

    out_item_t   expected_readings [$];
    int unsigned requests_used;
    int unsigned readings_predicted;
    int unsigned readings_checked;
    int unsigned status_seen [4];
    int unsigned mismatches;

    function new();
      wait_limit   = WAIT_LIMIT_RST;
      high_limit   = HIGH_LIMIT_RST;
      max_distance = MAX_DISTANCE_RST;
      phase        = PH_IDLE;
      tick_count   = '0;
      write_slot   = 0;
      ring_full    = 1'b0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_WAIT_LIMIT:   wait_limit   = value[TICK_W-1:0];
        REG_HIGH_LIMIT:   high_limit   = value[TICK_W-1:0];
        REG_MAX_DISTANCE: max_distance = value[DIST_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] register_value(logic [1:0] idx);
      case (idx)
        REG_WAIT_LIMIT:   return 32'(wait_limit);
        REG_HIGH_LIMIT:   return 32'(high_limit);
        REG_MAX_DISTANCE: return 32'(max_distance);
        default:          return '0;
      endcase
    endfunction

    // Floor average over the filled entries, 1 while nothing is stored.
    function logic [DIST_W-1:0] ring_average();
      int unsigned count;
      int unsigned sum;
      count = ring_full ? RING_DEPTH : write_slot;
      sum   = 0;
      if (count == 0) return DIST_W'(1);
      for (int i = 0; i < count; i++) sum += ring_cm[i];
      return DIST_W'(sum / count);
    endfunction

    function void close_reading(logic [DIST_W-1:0] raw, logic [STAT_W-1:0] status);
      out_item_t reading;
      reading.filtered_cm = ring_average();
      reading.raw_cm      = raw;
      reading.status      = status;
      expected_readings.push_back(reading);
      readings_predicted++;
      phase      = PH_IDLE;
      tick_count = '0;
    endfunction

    // Convert the pulse width, clamp it and store it when it lies in range.
    function void finish_reading();
      int unsigned ticks;
      int unsigned cm;
      ticks = tick_count;
      cm    = ticks * CM_NUM / CM_DEN;
      if (cm > max_distance) cm = max_distance;
      if (cm > 0 && cm < max_distance) begin
        ring_cm[write_slot] = DIST_W'(cm);
        write_slot++;
        if (write_slot == RING_DEPTH) begin
          write_slot = 0;
          ring_full  = 1'b1;
        end
        close_reading(DIST_W'(cm), ST_STORED);
      end else begin
        close_reading(DIST_W'(cm), ST_REJECTED);
      end
    endfunction

    function void note_request(in_item_t req);
      if (req.kind == KIND_START) begin
        // re-arm; a measurement in flight is dropped without a reading
        phase      = PH_WAIT;
        tick_count = '0;
        requests_used++;
      end else begin
        case (phase)
          PH_WAIT: begin
            requests_used++;
            if (req.echo) begin
              phase      = PH_HIGH;
              tick_count = '0;
            end else if (tick_count >= wait_limit) begin
              close_reading('0, ST_NO_START);
            end else begin
              tick_count++;
            end
          end
          PH_HIGH: begin
            requests_used++;
            if (!req.echo) begin
              finish_reading();
            end else if (tick_count >= high_limit) begin
              close_reading('0, ST_TOO_LONG);
            end else begin
              tick_count++;
            end
          end
          default: phase = PH_IDLE;  // tick while idle: ignored
        endcase
      end
    endfunction

    function void check_reading(out_item_t got);
      out_item_t want;
      if (expected_readings.size() == 0) begin
        $error("reading with none predicted: filtered_cm %0d raw_cm %0d status %0d",
               got.filtered_cm, got.raw_cm, got.status);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        status_seen[want.status]++;
        if (got.filtered_cm !== want.filtered_cm) begin
          $error("filtered_cm mismatch: expected %0d, got %0d", want.filtered_cm,
                 got.filtered_cm);
          mismatches++;
        end
        if (got.raw_cm !== want.raw_cm) begin
          $error("raw_cm mismatch: expected %0d, got %0d", want.raw_cm, got.raw_cm);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        push    = 1'b0;
  in_item_t    in_data = '0;
  logic        pop     = 1'b0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        full;
  logic        empty;
  out_item_t   out_data;
  logic [31:0] prdata;
  logic        pready;

  echo_range_scoreboard board = new();

  int unsigned burst_left     = 0;     // requests left in the current push burst
  int unsigned requests_sent  = 0;     // every request taken by the block
  bit          hold_requested = 1'b0;  // ask the result side for a long hold-off

  always #1 clk = ~clk;

  ultrasonic_echo_range_filter #(
    .WINDOW (RING_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Hold reset, then release it on a falling edge.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request and hold it until the block takes it. Requests come in
  // bursts; between bursts push usually drops for a random number of cycles,
  // and now and then a long burst runs with no gaps at all.
  task automatic send_request(logic kind, logic echo);
    in_item_t    req;
    int unsigned gap;
    req.kind = kind;
    req.echo = echo;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    push    <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (full) @(posedge clk);
    requests_sent++;
    board.note_request(req);
  endtask

  // One measurement: start, low ticks, high ticks (the first one is the rising
  // echo), then optionally the falling tick that completes it.
  task automatic send_measurement(int unsigned low_ticks, int unsigned high_ticks, bit close);
    send_request(KIND_START, 1'($urandom_range(0, 1)));
    repeat (low_ticks) send_request(KIND_TICK, 1'b0);
    repeat (high_ticks) send_request(KIND_TICK, 1'b1);
    if (close) send_request(KIND_TICK, 1'b0);
  endtask

  // Mostly well-formed measurements; some plain noise and some measurements
  // cut short, which the next start then drops.
  task automatic send_random_measurement(int unsigned max_low, int unsigned max_high);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 6))
        send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end else if (pick == 1) begin
      send_measurement($urandom_range(0, max_low), $urandom_range(0, max_high), 1'b0);
    end else begin
      send_measurement($urandom_range(0, max_low), $urandom_range(0, max_high), 1'b1);
    end
  endtask

  // Keep a phase running until it has sent the given number of requests.
  task automatic run_random_phase(int unsigned max_low, int unsigned max_high,
                                  int unsigned budget);
    int unsigned sent_at_start;
    sent_at_start = requests_sent;
    while (requests_sent - sent_at_start < budget)
      send_random_measurement(max_low, max_high);
  endtask

  // Drop push, wait for every predicted reading, then let the back end settle.
  // Anything still outstanding after the limit counts as a failure.
  task automatic wait_drained();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    push       <= 1'b0;
    burst_left = 0;
    while (board.expected_readings.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (board.expected_readings.size() != 0) begin
      $error("%0d predicted readings never arrived", board.expected_readings.size());
      board.mismatches += board.expected_readings.size();
      board.expected_readings.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(logic [1:0] idx);
    logic [31:0] want;
    want = board.register_value(idx);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("register %0d readback mismatch: expected 0x%08h, got 0x%08h", idx, want, prdata);
      board.mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write all three limits with junk above each register's width, then read
  // them back.
  task automatic configure(logic [15:0] w, logic [15:0] h, logic [8:0] m);
    write_register(REG_WAIT_LIMIT, ($urandom & 32'hFFFF_0000) | 32'(w));
    write_register(REG_HIGH_LIMIT, ($urandom & 32'hFFFF_0000) | 32'(h));
    write_register(REG_MAX_DISTANCE, ($urandom & 32'hFFFF_FE00) | 32'(m));
    check_register(REG_WAIT_LIMIT);
    check_register(REG_HIGH_LIMIT);
    check_register(REG_MAX_DISTANCE);
  endtask

  // --------------------------------------------------------------------------
  // Result side: pop on a changing pattern, with one long hold-off on request
  // --------------------------------------------------------------------------
  typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_MOSTLY} pop_style_t;

  initial begin : result_side
    pop_style_t  style;
    int unsigned style_left;
    int unsigned hold_left;
    int unsigned beat;
    style      = POP_ALWAYS;
    style_left = 0;
    hold_left  = 0;
    beat       = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      beat++;
      if (hold_requested) begin
        hold_left      = HOLD_CYCLES;
        hold_requested = 1'b0;
      end
      if (hold_left != 0) begin
        // hold off so the result and job queues back up into full
        hold_left--;
        pop <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = pop_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(8, 120);
        end
        style_left--;
        case (style)
          POP_ALWAYS: pop <= 1'b1;
          POP_COIN:   pop <= 1'($urandom_range(0, 1));
          POP_SPARSE: pop <= (beat % 4 == 0);
          default:    pop <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // Sample results at the rising edge: a reading moves when pop is high and
  // empty is low.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) board.check_reading(out_data);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    @(posedge rst_n);

    // reset values of the limits
    check_register(REG_WAIT_LIMIT);
    check_register(REG_HIGH_LIMIT);
    check_register(REG_MAX_DISTANCE);

    // Reset limits: ticks while idle are ignored, a second start re-arms,
    // and an echo that falls right after rising gives a zero, rejected reading
    // against an empty ring.
    send_request(KIND_TICK, 1'b0);
    send_request(KIND_TICK, 1'b1);
    send_request(KIND_START, 1'b0);
    send_request(KIND_START, 1'b1);
    send_request(KIND_TICK, 1'b1);
    send_request(KIND_TICK, 1'b0);
    wait_drained();

    // Zero limits and zero clamp: each timeout fires on its first counted
    // tick, and every distance clamps to zero and is rejected.
    configure(16'd0, 16'd0, 9'd0);
    send_measurement(0, 0, 1'b1);   // start timeout
    send_measurement(0, 2, 1'b0);   // pulse timeout
    send_measurement(0, 1, 1'b1);   // rejected at the zero clamp
    wait_drained();

    // Short wait limit with a small clamp: stored, rejected and start
    // timeouts mix; then one pulse long enough to clamp down to the limit.
    configure(16'd12, 16'd200, 9'd2);
    run_random_phase(16, 140, 150);
    send_measurement(0, 190, 1'b1);
    wait_drained();

    // Smallest nonzero limits; block the result side for a long stretch while
    // requests keep coming, so the block has to raise full.
    configure(16'd1, 16'd1, 9'd1);
    @(posedge clk);
    hold_requested = 1'b1;
    run_random_phase(3, 3, 150);
    wait_drained();

    // random small settings
    configure(16'($urandom_range(0, 40)), 16'($urandom_range(60, 150)),
              9'($urandom_range(0, 3)));
    run_random_phase(45, 160, 150);
    wait_drained();

    // Largest limits and clamp: a row of pulses that each store, adding to the
    // readings already held in the ring.
    configure(16'hFFFF, 16'hFFFF, 9'h1FF);
    repeat (4) send_measurement($urandom_range(0, 2), $urandom_range(60, 140), 1'b1);
    wait_drained();

    $display("covered %0d requests and %0d readings: %0d stored, %0d no echo start,",
             board.requests_used, board.readings_checked, board.status_seen[ST_STORED],
             board.status_seen[ST_NO_START]);
    $display("%0d echo too long, %0d rejected; limits ran from zero to full scale",
             board.status_seen[ST_TOO_LONG], board.status_seen[ST_REJECTED]);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, sized well beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
